>>> src/expanded_memory_page_mapper_unit_assert.svh
// ----------------------------------------------------------------------------
// expanded memory page mapper assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef EXPANDED_MEMORY_PAGE_MAPPER_UNIT_ASSERT_SVH
`define EXPANDED_MEMORY_PAGE_MAPPER_UNIT_ASSERT_SVH

// property checked only outside reset
`define EMSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define EMSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/emsm_pkg.sv
// ----------------------------------------------------------------------------
// emsm_pkg
// types, constants and codes shared by the page mapper modules
// ----------------------------------------------------------------------------
package emsm_pkg;

    localparam int STORE_BYTES = 1048576;
    localparam int SLOT_COUNT  = 4;
    localparam int SLOT_AW     = $clog2(SLOT_COUNT);
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int PAGE_W      = 8;
    localparam int PAGE_SHIFT  = 14;
    localparam int WIN_SHIFT   = 16;
    localparam int PHYS_W      = PAGE_W + PAGE_SHIFT;
    localparam int LIM_W       = PHYS_W + 1;
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 16;
    localparam int MSIZE_W     = 21;
    localparam int DATA_W      = 8;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [LIM_W-1:0]    STORE_LIM   = LIM_W'(STORE_BYTES);
    localparam logic [STORE_AW-1:0] STORE_LAST  = STORE_AW'(STORE_BYTES - 1);

    localparam logic [ADDR_W-1:0]  RST_WINDOW_BASE = 32'h000E_0000;
    localparam logic [PORT_W-1:0]  RST_PORT_BASE   = 16'h0260;
    localparam logic [MSIZE_W-1:0] RST_MEMORY_SIZE = 21'h10_0000;

    typedef enum logic [1:0] {
        MODE_MEM_RD  = 2'd0,
        MODE_MEM_WR  = 2'd1,
        MODE_PORT_RD = 2'd2,
        MODE_PORT_WR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_WINDOW_BASE = 2'd0,
        REG_PORT_BASE   = 2'd1,
        REG_MEMORY_SIZE = 2'd2,
        REG_NONE        = 2'd3
    } t_reg_idx;

    typedef logic [SLOT_COUNT-1:0][PAGE_W-1:0] t_pages;

    typedef struct packed {
        logic [ADDR_W-1:0]  window_base;
        logic [PORT_W-1:0]  port_base;
        logic [MSIZE_W-1:0] memory_size;
    } t_cfg;

    typedef struct packed {
        logic                hit;
        logic                mem_rd;
        logic                mem_wr;
        logic                port_rd;
        logic                port_wr;
        logic [STORE_AW-1:0] store_addr;
        logic [SLOT_AW-1:0]  reg_sel;
    } t_dec;

endpackage

>>> src/emsm_ram.sv
// ----------------------------------------------------------------------------
// emsm_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module emsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/emsm_decode.sv
// ----------------------------------------------------------------------------
// emsm_decode
// window, slot and port decode of one bus access
// ----------------------------------------------------------------------------
module emsm_decode (
    input  logic [1:0]                   i_mode,
    input  logic [emsm_pkg::ADDR_W-1:0]  i_mem_address,
    input  logic [emsm_pkg::PORT_W-1:0]  i_io_port,
    input  emsm_pkg::t_cfg               i_cfg,
    input  emsm_pkg::t_pages             i_pages,
    output emsm_pkg::t_dec               o_dec
);

    logic [emsm_pkg::ADDR_W-1:0]     rel;
    logic                            in_win;
    logic [emsm_pkg::SLOT_AW-1:0]    slot;
    logic [emsm_pkg::PHYS_W-1:0]     phys;
    logic [emsm_pkg::LIM_W-1:0]      msize;
    logic [emsm_pkg::LIM_W-1:0]      limit;
    logic                            mem_ok;
    logic [emsm_pkg::PORT_W-1:0]     prel;
    logic                            port_ok;

    always_comb begin
        rel    = i_mem_address - i_cfg.window_base;
        in_win = (i_mem_address >= i_cfg.window_base) &&
                 (rel[emsm_pkg::ADDR_W-1:emsm_pkg::WIN_SHIFT] == '0);
        slot   = rel[emsm_pkg::WIN_SHIFT-1:emsm_pkg::PAGE_SHIFT];
        phys   = {i_pages[slot], rel[emsm_pkg::PAGE_SHIFT-1:0]};
        msize  = emsm_pkg::LIM_W'(i_cfg.memory_size);
        // clamp to the store actually built
        limit  = (msize > emsm_pkg::STORE_LIM) ? emsm_pkg::STORE_LIM : msize;
        mem_ok = in_win && (emsm_pkg::LIM_W'(phys) < limit);

        prel    = i_io_port - i_cfg.port_base;
        port_ok = (i_io_port >= i_cfg.port_base) &&
                  (prel[emsm_pkg::PORT_W-1:emsm_pkg::SLOT_AW] == '0);

        o_dec            = '0;
        o_dec.store_addr = phys[emsm_pkg::STORE_AW-1:0];
        o_dec.reg_sel    = prel[emsm_pkg::SLOT_AW-1:0];
        case (emsm_pkg::t_mode'(i_mode))
            emsm_pkg::MODE_MEM_RD: begin
                o_dec.hit    = mem_ok;
                o_dec.mem_rd = mem_ok;
            end
            emsm_pkg::MODE_MEM_WR: begin
                o_dec.hit    = mem_ok;
                o_dec.mem_wr = mem_ok;
            end
            emsm_pkg::MODE_PORT_RD: begin
                o_dec.hit     = port_ok;
                o_dec.port_rd = port_ok;
            end
            emsm_pkg::MODE_PORT_WR: begin
                o_dec.hit     = port_ok;
                o_dec.port_wr = port_ok;
            end
            default: begin
                o_dec.hit = 1'b0;
            end
        endcase
    end

endmodule

>>> src/expanded_memory_page_mapper_unit.sv
// ----------------------------------------------------------------------------
// expanded_memory_page_mapper_unit
// expanded-memory page frame board: window decode, page registers, store
// ----------------------------------------------------------------------------
// Each access goes from its input transfer to a valid result in steps: it is
// captured, then decoded against the page registers while the single-port
// backing-store access is issued, then the store's registered read completes.
// One access is in flight at a time; the next input transfer is taken once
// the result has moved into the output register, which may still be waiting
// on the consumer. After reset the store is zeroed by a clearing pass over
// all STORE_BYTES bytes, one byte per cycle, during which no access is taken;
// configuration writes are accepted throughout. The APB registers
// sit at byte addresses 0 (window_base), 4 (port_base) and 8 (memory_size).
// ----------------------------------------------------------------------------
module expanded_memory_page_mapper_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [emsm_pkg::ADDR_W-1:0]   i_mem_address,
    input  logic [emsm_pkg::PORT_W-1:0]   i_io_port,
    input  logic [emsm_pkg::DATA_W-1:0]   i_write_data,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_hit,
    output logic [emsm_pkg::DATA_W-1:0]   o_read_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [emsm_pkg::PADDR_W-1:0]  paddr,
    input  logic [emsm_pkg::PDATA_W-1:0]  pwdata,
    output logic [emsm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_DECODE = 4'b0100,
        ST_RESP   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    emsm_pkg::t_cfg   r_cfg;
    emsm_pkg::t_pages r_pages;

    logic [emsm_pkg::STORE_AW-1:0] r_clr_addr;

    logic [1:0]                    r_mode;
    logic [emsm_pkg::ADDR_W-1:0]   r_addr;
    logic [emsm_pkg::PORT_W-1:0]   r_port;
    logic [emsm_pkg::DATA_W-1:0]   r_wdata;

    logic                          r_hit;
    logic                          r_mem_rd;
    logic [emsm_pkg::DATA_W-1:0]   r_port_rdata;

    logic                          r_out_valid;
    logic                          r_out_hit;
    logic [emsm_pkg::DATA_W-1:0]   r_out_data;

    emsm_pkg::t_dec                dec;
    logic                          in_xfer;
    logic                          cfg_wr;
    logic                          out_free;
    logic                          ram_we;
    logic                          ram_re;
    logic [emsm_pkg::STORE_AW-1:0] ram_addr;
    logic [emsm_pkg::DATA_W-1:0]   ram_wdata;
    logic [emsm_pkg::DATA_W-1:0]   ram_rdata;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || i_out_ready;

    emsm_decode u_decode (
        .i_mode        (r_mode),
        .i_mem_address (r_addr),
        .i_io_port     (r_port),
        .i_cfg         (r_cfg),
        .i_pages       (r_pages),
        .o_dec         (dec)
    );

    // clearing pass owns the port until it ends
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_re    = 1'b0;
            ram_addr  = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == ST_DECODE) && dec.mem_wr;
            ram_re    = (r_state == ST_DECODE) && dec.mem_rd;
            ram_addr  = dec.store_addr;
            ram_wdata = r_wdata;
        end
    end

    emsm_ram #(
        .WIDTH (emsm_pkg::DATA_W),
        .DEPTH (emsm_pkg::STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == emsm_pkg::STORE_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_pages     <= '0;
            r_cfg.window_base <= emsm_pkg::RST_WINDOW_BASE;
            r_cfg.port_base   <= emsm_pkg::RST_PORT_BASE;
            r_cfg.memory_size <= emsm_pkg::RST_MEMORY_SIZE;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (cfg_wr) begin
                case (emsm_pkg::t_reg_idx'(paddr[3:2]))
                    emsm_pkg::REG_WINDOW_BASE: r_cfg.window_base <= pwdata;
                    emsm_pkg::REG_PORT_BASE:
                        r_cfg.port_base <= pwdata[emsm_pkg::PORT_W-1:0];
                    emsm_pkg::REG_MEMORY_SIZE:
                        r_cfg.memory_size <= pwdata[emsm_pkg::MSIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == ST_DECODE) && dec.port_wr) begin
                r_pages[dec.reg_sel] <= r_wdata;
            end
            if ((r_state == ST_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode  <= i_mode;
            r_addr  <= i_mem_address;
            r_port  <= i_io_port;
            r_wdata <= i_write_data;
        end
        if (r_state == ST_DECODE) begin
            r_hit        <= dec.hit;
            r_mem_rd     <= dec.mem_rd;
            r_port_rdata <= dec.port_rd ? r_pages[dec.reg_sel] : '0;
        end
        if ((r_state == ST_RESP) && out_free) begin
            r_out_hit  <= r_hit;
            r_out_data <= r_mem_rd ? ram_rdata : r_port_rdata;
        end
    end

    always_comb begin
        case (emsm_pkg::t_reg_idx'(paddr[3:2]))
            emsm_pkg::REG_WINDOW_BASE: prdata = r_cfg.window_base;
            emsm_pkg::REG_PORT_BASE:
                prdata = emsm_pkg::PDATA_W'(r_cfg.port_base);
            emsm_pkg::REG_MEMORY_SIZE:
                prdata = emsm_pkg::PDATA_W'(r_cfg.memory_size);
            default: prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_read_data = r_out_data;

endmodule

>>> src/emsm_checker.sv
// ----------------------------------------------------------------------------
// emsm_checker
// port-level checks of the page mapper, bound to the top level
// ----------------------------------------------------------------------------
`include "expanded_memory_page_mapper_unit_assert.svh"

module emsm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic                          o_hit,
    input  logic [emsm_pkg::DATA_W-1:0]   o_read_data
);

    logic in_xfer;

    assign in_xfer = i_in_valid && o_in_ready;

    // a pending result is held until its transfer
    `EMSM_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid, "result dropped")

    // a miss never carries read data
    `EMSM_ASSERT(a_miss_zero, o_out_valid && !o_hit |-> o_read_data == '0, "miss with data")

    // one access in flight: input stays not ready through the decode and response states after an input transfer
    `EMSM_ASSERT(a_busy_after_in, in_xfer |=> !o_in_ready ##1 !o_in_ready, "access overlap")

    // nothing is offered right out of reset
    `EMSM_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out_valid && !o_in_ready, "not idle")

endmodule

bind expanded_memory_page_mapper_unit emsm_checker u_emsm_checker (.*);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the expanded memory page mapper unit
// ----------------------------------------------------------------------------
// A bus-level model of the board keeps its own page registers, backing store
// and configuration. It predicts hit and read data for every access taken on
// the input channel. Results are compared in order as they leave the block.
// A short directed run covers the window edges, the port decode, the memory
// size limit and zero size. It is followed by random phases under several
// window, port and size settings. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_LIMIT = 3 * emsm_pkg::STORE_BYTES;
    localparam int DRAIN_TAIL = 16;
    localparam int MAX_WAIT   = 13;

    typedef struct {
        int                         seq;
        bit                         hit;
        bit [emsm_pkg::DATA_W-1:0]  read_data;
    } t_bus_reply;

    class ems_board_model;
        logic [emsm_pkg::ADDR_W-1:0]  window_base;
        logic [emsm_pkg::PORT_W-1:0]  port_base;
        logic [emsm_pkg::MSIZE_W-1:0] memory_size;
        logic [emsm_pkg::PAGE_W-1:0]  page_regs [emsm_pkg::SLOT_COUNT];
        bit   [emsm_pkg::DATA_W-1:0]  store_bytes [int unsigned];
        t_bus_reply                   replies_due [$];
        int                           accesses;
        int                           errors;

        function new();
            window_base = emsm_pkg::RST_WINDOW_BASE;
            port_base   = emsm_pkg::RST_PORT_BASE;
            memory_size = emsm_pkg::RST_MEMORY_SIZE;
            foreach (page_regs[i]) page_regs[i] = '0;
            accesses = 0;
            errors   = 0;
        endfunction

        function void write_reg(emsm_pkg::t_reg_idx idx,
                                logic [emsm_pkg::PDATA_W-1:0] value);
            case (idx)
                emsm_pkg::REG_WINDOW_BASE: window_base = value;
                emsm_pkg::REG_PORT_BASE:   port_base   = value[emsm_pkg::PORT_W-1:0];
                emsm_pkg::REG_MEMORY_SIZE: memory_size = value[emsm_pkg::MSIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned size_limit();
            return (memory_size > emsm_pkg::STORE_BYTES) ? emsm_pkg::STORE_BYTES
                                                         : 32'(memory_size);
        endfunction

        // window decode, where is the store byte address on a hit
        function bit decode_mem(logic [emsm_pkg::ADDR_W-1:0] addr,
                                output int unsigned where);
            logic [emsm_pkg::ADDR_W-1:0] rel;
            where = 0;
            if (addr < window_base)
                return 0;
            rel = addr - window_base;
            if (rel >= 32'h0001_0000)
                return 0;
            where = 32'({page_regs[rel[15:14]], rel[13:0]});
            return where < size_limit();
        endfunction

        function bit decode_port(logic [emsm_pkg::PORT_W-1:0] port, output int slot);
            logic [emsm_pkg::PORT_W-1:0] rel;
            slot = 0;
            if (port < port_base)
                return 0;
            rel = port - port_base;
            if (rel >= emsm_pkg::SLOT_COUNT)
                return 0;
            slot = int'(rel);
            return 1;
        endfunction

        function void map_access(emsm_pkg::t_mode mode,
                                 logic [emsm_pkg::ADDR_W-1:0] addr,
                                 logic [emsm_pkg::PORT_W-1:0] port,
                                 logic [emsm_pkg::DATA_W-1:0] data);
            t_bus_reply  r;
            int unsigned where;
            int          slot;
            r.seq       = accesses;
            r.hit       = 1'b0;
            r.read_data = '0;
            accesses++;
            case (mode)
                emsm_pkg::MODE_MEM_RD: begin
                    r.hit = decode_mem(addr, where);
                    if (r.hit && store_bytes.exists(where))
                        r.read_data = store_bytes[where];
                end
                emsm_pkg::MODE_MEM_WR: begin
                    r.hit = decode_mem(addr, where);
                    if (r.hit)
                        store_bytes[where] = data;
                end
                emsm_pkg::MODE_PORT_RD: begin
                    r.hit = decode_port(port, slot);
                    if (r.hit)
                        r.read_data = page_regs[slot];
                end
                default: begin
                    r.hit = decode_port(port, slot);
                    if (r.hit)
                        page_regs[slot] = data;
                end
            endcase
            replies_due.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_reply(logic hit, logic [emsm_pkg::DATA_W-1:0] read_data);
            t_bus_reply r;
            if (replies_due.size() == 0) begin
                report($sformatf("result with no access pending, hit=%b data=%02h",
                                 hit, read_data));
                return;
            end
            r = replies_due.pop_front();
            if (hit !== r.hit)
                report($sformatf("access %0d hit %b, expected %b", r.seq, hit, r.hit));
            if (read_data !== r.read_data)
                report($sformatf("access %0d read_data %02h, expected %02h",
                                 r.seq, read_data, r.read_data));
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [1:0]                    i_mode;
    logic [emsm_pkg::ADDR_W-1:0]   i_mem_address;
    logic [emsm_pkg::PORT_W-1:0]   i_io_port;
    logic [emsm_pkg::DATA_W-1:0]   i_write_data;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_hit;
    logic [emsm_pkg::DATA_W-1:0]   o_read_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [emsm_pkg::PADDR_W-1:0]  paddr;
    logic [emsm_pkg::PDATA_W-1:0]  pwdata;
    logic [emsm_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    ems_board_model board = new();
    bit send_steady = 1'b0;
    bit sink_steady = 1'b0;

    expanded_memory_page_mapper_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_mem_address (i_mem_address),
        .i_io_port     (i_io_port),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hit         (o_hit),
        .o_read_data   (o_read_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic apb_write(emsm_pkg::t_reg_idx idx, logic [emsm_pkg::PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, value);
    endtask

    // drop valid so the last payload is not taken twice, then wait for results
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (board.replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_access(emsm_pkg::t_mode mode,
                               logic [emsm_pkg::ADDR_W-1:0] addr,
                               logic [emsm_pkg::PORT_W-1:0] port,
                               logic [emsm_pkg::DATA_W-1:0] data);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_mem_address <= addr;
        i_io_port     <= port;
        i_write_data  <= data;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        board.map_access(mode, addr, port, data);
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
    endtask

    task automatic send_random_access();
        emsm_pkg::t_mode             mode;
        logic [emsm_pkg::ADDR_W-1:0] addr;
        logic [emsm_pkg::PORT_W-1:0] port;
        logic [emsm_pkg::DATA_W-1:0] data;
        int unsigned                 pages;
        mode = emsm_pkg::t_mode'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: addr = board.window_base + $urandom_range(0, 16'hFFFF);
            // few offsets per slot so reads find earlier writes
            4, 5, 6: addr = board.window_base
                            + ($urandom_range(0, 3) << emsm_pkg::PAGE_SHIFT)
                            + $urandom_range(0, 15);
            7: begin
                case ($urandom_range(0, 2))
                    0:       addr = board.window_base - 1;
                    1:       addr = board.window_base + 32'h0001_0000;
                    default: addr = board.window_base + 32'h0000_FFFF;
                endcase
            end
            default: addr = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6:
                port = board.port_base + emsm_pkg::PORT_W'($urandom_range(0, 3));
            7: port = $urandom_range(0, 1) ? emsm_pkg::PORT_W'(board.port_base - 1)
                                           : emsm_pkg::PORT_W'(board.port_base + 4);
            default: port = emsm_pkg::PORT_W'($urandom);
        endcase
        // page values that land inside the memory size in most page writes
        pages = (board.size_limit() + 16383) >> emsm_pkg::PAGE_SHIFT;
        if (mode == emsm_pkg::MODE_PORT_WR && pages > 0 && $urandom_range(0, 2) != 0)
            data = emsm_pkg::DATA_W'($urandom_range(0, pages - 1));
        else
            data = emsm_pkg::DATA_W'($urandom);
        send_access(mode, addr, port, data);
        if ($urandom_range(0, 49) == 0)
            drain_replies();
    endtask

    task automatic run_phase(logic [emsm_pkg::ADDR_W-1:0] wbase,
                             logic [emsm_pkg::PORT_W-1:0] pbase,
                             logic [emsm_pkg::MSIZE_W-1:0] msize, int count);
        drain_replies();
        apb_write(emsm_pkg::REG_NONE, $urandom);
        apb_write(emsm_pkg::REG_WINDOW_BASE, wbase);
        apb_write(emsm_pkg::REG_PORT_BASE, emsm_pkg::PDATA_W'(pbase));
        apb_write(emsm_pkg::REG_MEMORY_SIZE, emsm_pkg::PDATA_W'(msize));
        repeat (count) send_random_access();
    endtask

    // result side: random stall before each transfer, steady stretches too
    initial begin : result_sink
        int stall;
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid && i_out_ready));
            board.check_reply(o_hit, o_read_data);
            if ($urandom_range(0, 39) == 0)
                sink_steady = !sink_steady;
        end
    end

    // no access is taken during the clearing pass after reset; the idle limit allows for it
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_mode        <= emsm_pkg::MODE_MEM_RD;
        i_mem_address <= '0;
        i_io_port     <= '0;
        i_write_data  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: page registers and store read back as zero
        send_access(emsm_pkg::MODE_PORT_RD, 32'h0,         16'h0260, 8'h00);
        send_access(emsm_pkg::MODE_MEM_RD,  32'h000E_0000, 16'h0,    8'h00);
        send_access(emsm_pkg::MODE_MEM_WR,  32'h000E_0000, 16'h0,    8'hFF);
        // slot 1 aliases slot 0 while both pages are zero
        send_access(emsm_pkg::MODE_MEM_RD,  32'h000E_4000, 16'h0,    8'h00);
        send_access(emsm_pkg::MODE_PORT_WR, 32'h0,         16'h0263, 8'hFF);
        send_access(emsm_pkg::MODE_PORT_RD, 32'h0,         16'h0263, 8'h00);
        // page 0xff lies beyond the memory size
        send_access(emsm_pkg::MODE_MEM_WR,  32'h000E_FFFF, 16'h0,    8'h5A);
        send_access(emsm_pkg::MODE_PORT_WR, 32'h0,         16'h0263, 8'h3F);
        send_access(emsm_pkg::MODE_MEM_WR,  32'h000E_FFFF, 16'h0,    8'h5A);
        send_access(emsm_pkg::MODE_MEM_RD,  32'h000E_FFFF, 16'h0,    8'h00);
        send_access(emsm_pkg::MODE_MEM_RD,  32'h000D_FFFF, 16'h0,    8'h00);
        send_access(emsm_pkg::MODE_MEM_RD,  32'h000F_0000, 16'h0,    8'h00);
        send_access(emsm_pkg::MODE_MEM_WR,  32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_access(emsm_pkg::MODE_MEM_RD,  32'h0,         16'h0,    8'h00);
        send_access(emsm_pkg::MODE_PORT_WR, 32'h0,         16'h025F, 8'h11);
        send_access(emsm_pkg::MODE_PORT_WR, 32'h0,         16'h0264, 8'h22);
        send_access(emsm_pkg::MODE_PORT_RD, 32'h0,         16'hFFFF, 8'h00);
        send_access(emsm_pkg::MODE_PORT_RD, 32'h0,         16'h0000, 8'h00);

        // window and ports at the very top, zero memory size
        drain_replies();
        apb_write(emsm_pkg::REG_NONE, 32'hFFFF_FFFF);
        apb_write(emsm_pkg::REG_WINDOW_BASE, 32'hFFFF_0000);
        apb_write(emsm_pkg::REG_PORT_BASE, 32'h0000_FFFC);
        apb_write(emsm_pkg::REG_MEMORY_SIZE, 32'h0);
        send_access(emsm_pkg::MODE_MEM_WR,  32'hFFFF_0000, 16'h0,    8'h77);
        send_access(emsm_pkg::MODE_PORT_WR, 32'h0,         16'hFFFF, 8'h3F);
        send_access(emsm_pkg::MODE_PORT_RD, 32'h0,         16'hFFFF, 8'h00);
        send_access(emsm_pkg::MODE_PORT_RD, 32'h0,         16'hFFFB, 8'h00);
        drain_replies();
        apb_write(emsm_pkg::REG_MEMORY_SIZE, emsm_pkg::PDATA_W'(emsm_pkg::STORE_BYTES));
        send_access(emsm_pkg::MODE_MEM_WR,  32'hFFFF_FFFF, 16'h0,    8'hA5);
        send_access(emsm_pkg::MODE_MEM_RD,  32'hFFFF_FFFF, 16'h0,    8'h00);

        run_phase(32'h0000_0000, 16'h0000, 21'h10_0000, 170);
        run_phase(32'h1234_0000, 16'h8000, 21'h00_4000, 160);
        run_phase(32'hFFFF_0000, 16'hFFFC, 21'h0F_FFFF, 160);
        run_phase(32'hABCD_E123, 16'h1234, 21'h08_0001, 160);
        run_phase($urandom, emsm_pkg::PORT_W'($urandom),
                  emsm_pkg::MSIZE_W'($urandom_range(0, emsm_pkg::STORE_BYTES)), 180);
        run_phase(emsm_pkg::RST_WINDOW_BASE, emsm_pkg::RST_PORT_BASE, 21'h00_0001, 80);

        drain_replies();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> expanded_memory_page_mapper_unit.f
+incdir+src
src/emsm_pkg.sv
src/emsm_ram.sv
src/emsm_decode.sv
src/expanded_memory_page_mapper_unit.sv
src/emsm_checker.sv
sim/tb.sv
